>>> rtl/core/rc5_pkg.sv
// RC5-32/12/4 shared package: sizes, magic constants, command types and
// rotate/address helpers. No dependencies; used by rc5_dp, rc5_ctrl and rc5_block_cipher.
`timescale 1ns / 1ps

package rc5_pkg;

	localparam int ROUNDS      = 12;
	localparam int TABLE_WORDS = 2 * ROUNDS + 2;
	localparam int MIX_PASSES  = 3;

	localparam int WORD_W = 32;
	localparam int ROT_W  = 5;
	localparam int CNT_W  = $clog2(ROUNDS + 1);
	localparam int AW     = $clog2(TABLE_WORDS);
	localparam int PASS_W = $clog2(MIX_PASSES);

	localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
	localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;
	localparam logic [ROT_W-1:0]  KEY_ROT = 5'd3;

	typedef enum logic {
		OP_ENC = 1'b0,
		OP_DEC = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		RND_HOLD,
		RND_LOAD,
		RND_WHITEN,
		RND_ENC,
		RND_DEC,
		RND_UNWHITEN
	} rnd_op_t;

	typedef struct packed {
		rnd_op_t        rnd;
		logic           out_load;
		logic           exp_start;
		logic           exp_step;
		logic           exp_pass1;
		logic [AW-1:0]  rd_addr_a;
		logic [AW-1:0]  rd_addr_b;
		logic [AW-1:0]  wr_addr;
	} cmd_t;

	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
			input logic [ROT_W-1:0] n);
		logic [2*WORD_W-1:0] dbl;
		dbl = {x, x} << n;
		return dbl[2*WORD_W-1:WORD_W];
	endfunction

	function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
			input logic [ROT_W-1:0] n);
		logic [2*WORD_W-1:0] dbl;
		dbl = {x, x} >> n;
		return dbl[WORD_W-1:0];
	endfunction

	// Key pair used by round step c: forward order for encrypt, reverse for decrypt
	// with the whitening pair last.
	function automatic logic [CNT_W-1:0] pair_for(input op_t op, input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] p;
		if (op == OP_ENC) begin
			p = c;
		end else if (c == CNT_W'(ROUNDS)) begin
			p = '0;
		end else begin
			p = CNT_W'(ROUNDS) - c;
		end
		return p;
	endfunction

	function automatic logic [AW-1:0] pair_addr(input logic [CNT_W-1:0] pair, input logic odd);
		return AW'({pair, odd});
	endfunction

endpackage

>>> rtl/core/rc5_dp.sv
// RC5 datapath: round key memory, key expansion mixer, round unit and
// output register. Driven by rc5_ctrl through cmd_t; uses rc5_pkg.
`timescale 1ns / 1ps

module rc5_dp
	import rc5_pkg::*;
(
	input  logic              clk,
	input  cmd_t              cmd,
	input  logic [WORD_W-1:0] key,
	input  logic [WORD_W-1:0] in_first,
	input  logic [WORD_W-1:0] in_second,
	output logic [WORD_W-1:0] out_first,
	output logic [WORD_W-1:0] out_second
);

	logic [WORD_W-1:0] rk_mem [TABLE_WORDS];
	logic [WORD_W-1:0] rd_a_q, rd_b_q;

	logic [WORD_W-1:0] a_q, b_q;
	logic [WORD_W-1:0] ka_q, kb_q, l_q, init_q;
	logic [WORD_W-1:0] out_first_q, out_second_q;

	logic [WORD_W-1:0] s_old, ka_nxt, kb_nxt, kab;
	logic [WORD_W-1:0] a_nxt, b_nxt;

	// Mixing step: first pass takes the P/Q sequence, later passes the stored table.
	always_comb begin
		s_old  = cmd.exp_pass1 ? init_q : rd_a_q;
		ka_nxt = rotl32(s_old + ka_q + kb_q, KEY_ROT);
		kab    = ka_nxt + kb_q;
		kb_nxt = rotl32(l_q + kab, kab[ROT_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_step) begin
			rk_mem[cmd.wr_addr] <= ka_nxt;
		end
		rd_a_q <= rk_mem[cmd.rd_addr_a];
		rd_b_q <= rk_mem[cmd.rd_addr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			l_q    <= key;
			ka_q   <= '0;
			kb_q   <= '0;
			init_q <= MAGIC_P;
		end else if (cmd.exp_step) begin
			l_q    <= kb_nxt;
			ka_q   <= ka_nxt;
			kb_q   <= kb_nxt;
			init_q <= init_q + MAGIC_Q;
		end
	end

	always_comb begin
		logic [WORD_W-1:0] t;
		t     = '0;
		a_nxt = a_q;
		b_nxt = b_q;
		unique case (cmd.rnd)
			RND_HOLD: begin
			end
			RND_LOAD: begin
				a_nxt = in_first;
				b_nxt = in_second;
			end
			RND_WHITEN: begin
				a_nxt = a_q + rd_a_q;
				b_nxt = b_q + rd_b_q;
			end
			RND_ENC: begin
				t     = rotl32(a_q ^ b_q, b_q[ROT_W-1:0]) + rd_a_q;
				a_nxt = t;
				b_nxt = rotl32(b_q ^ t, t[ROT_W-1:0]) + rd_b_q;
			end
			RND_DEC: begin
				t     = rotr32(b_q - rd_b_q, a_q[ROT_W-1:0]) ^ a_q;
				b_nxt = t;
				a_nxt = rotr32(a_q - rd_a_q, t[ROT_W-1:0]) ^ t;
			end
			RND_UNWHITEN: begin
				a_nxt = a_q - rd_a_q;
				b_nxt = b_q - rd_b_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		a_q <= a_nxt;
		b_q <= b_nxt;
		if (cmd.out_load) begin
			out_first_q  <= a_q;
			out_second_q <= b_q;
		end
	end

	assign out_first  = out_first_q;
	assign out_second = out_second_q;

endmodule

>>> rtl/core/rc5_ctrl.sv
// RC5 controller: sequences key expansion and the round steps, owns the
// stream handshakes and issues cmd_t to rc5_dp. Uses rc5_pkg.
`timescale 1ns / 1ps

module rc5_ctrl
	import rc5_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic s_tvalid,
	input  logic s_op,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd
);

	state_t            state_q, state_nxt;
	logic              ready_q, ready_nxt;
	logic              out_valid_q, out_valid_nxt;
	op_t               op_q, op_nxt;
	logic [CNT_W-1:0]  cnt_q, cnt_nxt;
	logic [AW-1:0]     ti_q, ti_nxt;
	logic [PASS_W-1:0] pass_q, pass_nxt;

	logic out_free, accept, ti_wrap;
	op_t  in_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
			op_q        <= OP_ENC;
			cnt_q       <= '0;
			ti_q        <= '0;
			pass_q      <= '0;
		end else begin
			state_q     <= state_nxt;
			ready_q     <= ready_nxt;
			out_valid_q <= out_valid_nxt;
			op_q        <= op_nxt;
			cnt_q       <= cnt_nxt;
			ti_q        <= ti_nxt;
			pass_q      <= pass_nxt;
		end
	end

	always_comb begin
		in_op    = op_t'(s_op);
		out_free = !out_valid_q || m_tready;
		ti_wrap  = (ti_q == AW'(TABLE_WORDS - 1));

		state_nxt = state_q;
		ready_nxt = ready_q;
		op_nxt    = op_q;
		cnt_nxt   = cnt_q;
		ti_nxt    = ti_q;
		pass_nxt  = pass_q;
		s_tready  = 1'b0;

		cmd           = '0;
		cmd.rnd       = RND_HOLD;
		cmd.exp_pass1 = (pass_q == '0);
		cmd.wr_addr   = ti_q;
		cmd.rd_addr_a = pair_addr(pair_for(in_op, '0), 1'b0);
		cmd.rd_addr_b = pair_addr(pair_for(in_op, '0), 1'b1);

		unique case (state_q)
			ST_IDLE: begin
				s_tready = ready_q;
			end
			ST_EXPAND: begin
				cmd.exp_step  = 1'b1;
				cmd.rd_addr_a = ti_wrap ? '0 : ti_q + 1'b1;
				ti_nxt        = ti_wrap ? '0 : ti_q + 1'b1;
				if (ti_wrap) begin
					pass_nxt = pass_q + 1'b1;
					if (pass_q == PASS_W'(MIX_PASSES - 1)) begin
						state_nxt = ST_IDLE;
						ready_nxt = 1'b1;
					end
				end
			end
			ST_RUN: begin
				if (op_q == OP_ENC) begin
					cmd.rnd = (cnt_q == '0) ? RND_WHITEN : RND_ENC;
				end else begin
					cmd.rnd = (cnt_q == CNT_W'(ROUNDS)) ? RND_UNWHITEN : RND_DEC;
				end
				// prefetch the pair for the following step
				if (cnt_q == CNT_W'(ROUNDS)) begin
					cmd.rd_addr_a = '0;
					cmd.rd_addr_b = '0;
					state_nxt     = ST_DONE;
				end else begin
					cmd.rd_addr_a = pair_addr(pair_for(op_q, cnt_q + 1'b1), 1'b0);
					cmd.rd_addr_b = pair_addr(pair_for(op_q, cnt_q + 1'b1), 1'b1);
					cnt_nxt       = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				s_tready = ready_q && out_free;
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase

		accept = s_tvalid && s_tready;
		if (accept) begin
			cmd.rnd   = RND_LOAD;
			op_nxt    = in_op;
			cnt_nxt   = '0;
			state_nxt = ST_RUN;
		end

		// a key write restarts expansion and blocks items until it ends
		if (cfg_we) begin
			cmd.exp_start = 1'b1;
			cmd.exp_step  = 1'b0;
			state_nxt     = ST_EXPAND;
			ready_nxt     = 1'b0;
			ti_nxt        = '0;
			pass_nxt      = '0;
		end

		out_valid_nxt = cmd.out_load || (out_valid_q && !m_tready);
	end

	assign m_tvalid = out_valid_q;

endmodule

>>> rtl/core/rc5_block_cipher.sv
// RC5-32/12/4: one block at a time through the shared round unit (13 steps,
// one table pair each), then into the output register.
// A key write runs key expansion (3 passes over 26 table words)
// with s_tready low. Async reset clears control only; no items are taken
// until a key has been written. The output register frees the core early.
`timescale 1ns / 1ps

module rc5_block_cipher
	import rc5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,  // cipher_key
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // first_word [31:0], second_word [63:32]
	input  logic [0:0]  s_tuser,    // operation [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata     // out_first [31:0], out_second [63:32]
);

	cmd_t              cmd;
	logic [WORD_W-1:0] out_first, out_second;

	rc5_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser[0]),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rc5_dp u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.key        (cfg_wdata),
		.in_first   (s_tdata[31:0]),
		.in_second  (s_tdata[63:32]),
		.out_first  (out_first),
		.out_second (out_second)
	);

	assign m_tdata = {out_second, out_first};

endmodule

>>> rtl/core/rc5_chk.sv
// Port-level checker for rc5_block_cipher, attached by bind.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps

module rc5_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [31:0] cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed while stalled");

	a_key_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("input taken during key expansion");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat accepted while a block is in flight");

	// the previous block may still be handed over in the accepting cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> ##1 !$rose(m_tvalid))
		else $error("result appeared right after input beat");

endmodule

bind rc5_block_cipher rc5_chk u_rc5_chk (.*);
